// ----- rtl/core/rabe_pkg.sv -----
// ---------------------------------------------------------------------------
// rabe_pkg
// shared types and constants of the register alu and branch executor
// ---------------------------------------------------------------------------
`default_nettype none

package rabe_pkg;

   localparam int NUM_REGS  = 8;
   localparam int REG_WIDTH = 32;
   localparam int ADDR_W    = $clog2(NUM_REGS);

   localparam logic [4:0] CMD_NOP    = 5'd0;
   localparam logic [4:0] CMD_RET    = 5'd1;
   localparam logic [4:0] CMD_ERROR  = 5'd2;
   localparam logic [4:0] CMD_SET    = 5'd3;
   localparam logic [4:0] CMD_INC    = 5'd4;
   localparam logic [4:0] CMD_ADD_RI = 5'd5;
   localparam logic [4:0] CMD_ADD_RR = 5'd6;
   localparam logic [4:0] CMD_SUB_RI = 5'd7;
   localparam logic [4:0] CMD_SUB_RR = 5'd8;
   localparam logic [4:0] CMD_AND_RR = 5'd9;
   localparam logic [4:0] CMD_AND_RI = 5'd10;
   localparam logic [4:0] CMD_OR_RR  = 5'd11;
   localparam logic [4:0] CMD_OR_RI  = 5'd12;
   localparam logic [4:0] CMD_XOR_RR = 5'd13;
   localparam logic [4:0] CMD_XOR_RI = 5'd14;
   localparam logic [4:0] CMD_BEQ_RR = 5'd15;
   localparam logic [4:0] CMD_BEQ_RI = 5'd16;
   localparam logic [4:0] CMD_BEZ    = 5'd17;
   localparam logic [4:0] CMD_BNZ    = 5'd18;
   localparam logic [4:0] CMD_BLT    = 5'd19;
   localparam logic [4:0] CMD_JMP    = 5'd20;

   typedef struct packed {
      logic [4:0]         cmd;
      logic [2:0]         dest_reg;
      logic [2:0]         src_a_reg;
      logic [2:0]         src_b_reg;
      logic signed [31:0] immediate;
      logic [15:0]        target_label;
      logic [2:0]         ret_code;
   } req_type;

   typedef struct packed {
      logic               reg_written;
      logic [2:0]         written_index;
      logic signed [31:0] written_value;
      logic               branch_taken;
      logic [15:0]        branch_target;
      logic               exit_now;
      logic               exit_is_error;
      logic [2:0]         exit_code;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/rabe_ram.sv -----
// ---------------------------------------------------------------------------
// rabe_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module rabe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/register_alu_branch_executor.sv -----
// ---------------------------------------------------------------------------
// register_alu_branch_executor
// executes one integer alu or branch instruction per item on a register file
// ---------------------------------------------------------------------------
//  channel | ports                          | direction | payload
//  req     | req_valid req_ready req_data   | in        | rabe_pkg::req_type
//  rsp     | rsp_valid rsp_ready rsp_data   | out       | rabe_pkg::rsp_type
//
//  one item per cycle while rsp is not stalled; a req passes the execute and rsp registers
//  the accept edge loads the execute register and the registered ram read;
//  the execute stage forwards the last write, runs the alu and branch compare
//  and loads the rsp register when it advances
//  reset clears the register file via per-entry valid bits, no sweep needed
//  a stalled rsp holds the execute stage; req_ready drops only when both fill
// ---------------------------------------------------------------------------
`default_nettype none

module register_alu_branch_executor (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rabe_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rabe_pkg::rsp_type      rsp_data
);

   localparam int AW = rabe_pkg::ADDR_W;
   localparam int RW = rabe_pkg::REG_WIDTH;

   logic              req_fire;
   logic              ex_advance;

   // execute stage
   logic              ex_valid_ff;
   logic              ex_valid_in;
   rabe_pkg::req_type ex_req_ff;
   logic [2:0]        ex_b_idx_ff;
   logic [2:0]        port_b_idx;

   // register file
   logic [RW-1:0]     ram_a;
   logic [RW-1:0]     ram_b;
   logic [rabe_pkg::NUM_REGS-1:0] reg_valid_ff;
   logic              last_wr_valid_ff;
   logic [AW-1:0]     last_wr_idx_ff;
   logic [RW-1:0]     last_wr_data_ff;

   // result
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rabe_pkg::rsp_type rsp_ff;
   rabe_pkg::rsp_type rsp_in;

   logic              wr_en;
   logic [RW-1:0]     wr_val;
   logic [RW-1:0]     op_a;
   logic [RW-1:0]     op_b;
   logic [RW-1:0]     imm_r;
   logic signed [63:0] a_ext;
   logic signed [63:0] imm_ext;
   logic              taken;
   logic              dest_ok;

   function automatic logic [RW-1:0] read_operand(
      input logic [2:0]                    idx,
      input logic [RW-1:0]                 ram_data,
      input logic [rabe_pkg::NUM_REGS-1:0] valid_bits,
      input logic                          lw_valid,
      input logic [AW-1:0]                 lw_idx,
      input logic [RW-1:0]                 lw_data
   );
      logic [RW-1:0] val;
      val = '0;
      if (32'(idx) < rabe_pkg::NUM_REGS) begin
         if (lw_valid && lw_idx == idx[AW-1:0]) begin
            val = lw_data;
         end else if (valid_bits[idx[AW-1:0]]) begin
            val = ram_data;
         end
      end
      return val;
   endfunction

   assign ex_advance = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !ex_valid_ff || ex_advance;
   assign req_fire   = req_valid && req_ready;

   // increment reads its destination on the second port
   assign port_b_idx = (req_data.cmd == rabe_pkg::CMD_INC) ? req_data.dest_reg
                                                          : req_data.src_b_reg;

   rabe_ram #(
      .WIDTH (RW),
      .DEPTH (rabe_pkg::NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ex_req_ff.dest_reg[AW-1:0]),
      .wr_data   (wr_val),
      .rd_en     (req_fire),
      .rd_addr_a (req_data.src_a_reg[AW-1:0]),
      .rd_addr_b (port_b_idx[AW-1:0]),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_comb begin
      op_a = read_operand(ex_req_ff.src_a_reg, ram_a, reg_valid_ff,
                          last_wr_valid_ff, last_wr_idx_ff, last_wr_data_ff);
      op_b = read_operand(ex_b_idx_ff, ram_b, reg_valid_ff,
                          last_wr_valid_ff, last_wr_idx_ff, last_wr_data_ff);
   end

   assign imm_r   = RW'(ex_req_ff.immediate);
   assign a_ext   = 64'($signed(op_a));
   assign imm_ext = 64'(ex_req_ff.immediate);
   assign dest_ok = 32'(ex_req_ff.dest_reg) < rabe_pkg::NUM_REGS;

   always_comb begin
      rsp_in = '0;
      wr_val = '0;
      taken  = 1'b0;
      rsp_in.reg_written = 1'b0;
      unique case (ex_req_ff.cmd)
         rabe_pkg::CMD_RET: begin
            rsp_in.exit_now  = 1'b1;
            rsp_in.exit_code = ex_req_ff.ret_code;
         end
         rabe_pkg::CMD_ERROR: begin
            rsp_in.exit_now      = 1'b1;
            rsp_in.exit_is_error = 1'b1;
         end
         rabe_pkg::CMD_SET:    begin wr_val = imm_r;        rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_INC:    begin wr_val = op_b + 1'b1;  rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_ADD_RI: begin wr_val = op_a + imm_r; rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_ADD_RR: begin wr_val = op_a + op_b;  rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_SUB_RI: begin wr_val = op_a - imm_r; rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_SUB_RR: begin wr_val = op_a - op_b;  rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_AND_RR: begin wr_val = op_a & op_b;  rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_AND_RI: begin wr_val = op_a & imm_r; rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_OR_RR:  begin wr_val = op_a | op_b;  rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_OR_RI:  begin wr_val = op_a | imm_r; rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_XOR_RR: begin wr_val = op_a ^ op_b;  rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_XOR_RI: begin wr_val = op_a ^ imm_r; rsp_in.reg_written = 1'b1; end
         rabe_pkg::CMD_BEQ_RR: taken = (op_a == op_b);
         rabe_pkg::CMD_BEQ_RI: taken = (a_ext == imm_ext);
         rabe_pkg::CMD_BEZ:    taken = (op_a == '0);
         rabe_pkg::CMD_BNZ:    taken = (op_a != '0);
         rabe_pkg::CMD_BLT:    taken = (a_ext < imm_ext);
         rabe_pkg::CMD_JMP:    taken = 1'b1;
         default: ;
      endcase
      if (!dest_ok) begin
         rsp_in.reg_written = 1'b0;
      end
      if (rsp_in.reg_written) begin
         rsp_in.written_index = ex_req_ff.dest_reg;
         rsp_in.written_value = 32'($signed(wr_val));
      end
      rsp_in.branch_taken = taken;
      if (taken) begin
         rsp_in.branch_target = ex_req_ff.target_label;
      end
   end

   assign wr_en = ex_advance && rsp_in.reg_written;

   assign ex_valid_in  = req_fire || (ex_valid_ff && !ex_advance);
   assign rsp_valid_in = ex_advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         reg_valid_ff     <= '0;
         last_wr_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            reg_valid_ff[ex_req_ff.dest_reg[AW-1:0]] <= 1'b1;
            last_wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_req_ff   <= req_data;
         ex_b_idx_ff <= port_b_idx;
      end
      if (ex_advance) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         last_wr_idx_ff  <= ex_req_ff.dest_reg[AW-1:0];
         last_wr_data_ff <= wr_val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
